// ===== hdl/bci_pkg.sv =====
// ----------------------------------------------------------------------------
// bci_pkg
// Shared widths, register indexes and pipeline layout for the barycentric
// color interpolator.
// ----------------------------------------------------------------------------
package bci_pkg;

  localparam int COORD_W    = 16;
  localparam int COLOR_FRAC = 12;
  localparam int WEIGHT_FRAC = 16;
  localparam int LANE_W     = COLOR_FRAC + 1;
  localparam int RGB_W      = 3 * LANE_W;
  localparam int VTX_W      = 2 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RGB_W;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = SUM_W + WEIGHT_FRAC;
  localparam int QUO_W  = WEIGHT_FRAC + 17;
  localparam int CMP_W  = SUM_W + QUO_W;
  localparam int WGT_W  = QUO_W + 1;
  localparam int W2_W   = WGT_W + 1;
  localparam int MUL_W  = LANE_W + 1 + W2_W;
  localparam int ACC_W  = MUL_W + 2;

  localparam int ST_DIV0 = 4;
  localparam int N_DIV   = QUO_W;
  localparam int ST_WGT  = ST_DIV0 + N_DIV;
  localparam int ST_MUL  = ST_WGT + 1;
  localparam int ST_ACC  = ST_MUL + 1;
  localparam int ST_OUT  = ST_ACC + 1;
  localparam int N_ST    = ST_OUT + 1;

  localparam logic [LANE_W-1:0] COLOR_ONE = LANE_W'(1) << COLOR_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX0 = 3'd0,
    REG_VERTEX1 = 3'd1,
    REG_VERTEX2 = 3'd2,
    REG_COLOR0  = 3'd3,
    REG_COLOR1  = 3'd4,
    REG_COLOR2  = 3'd5
  } cfg_idx_t;

endpackage

// ===== hdl/bci_if.sv =====
// ----------------------------------------------------------------------------
// bci channel interfaces
// Pixel input, color result and configuration write channels.
// ----------------------------------------------------------------------------
interface bci_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [bci_pkg::COORD_W-1:0]  pixel_x;
  logic signed [bci_pkg::COORD_W-1:0]  pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bci_color_if;
  logic                             valid;
  logic                             ready;
  logic [bci_pkg::LANE_W-1:0]       red;
  logic [bci_pkg::LANE_W-1:0]       green;
  logic [bci_pkg::LANE_W-1:0]       blue;
  logic                             degenerate;
  logic                             saturated;
  modport source (output valid, red, green, blue, degenerate, saturated, input ready);
  modport sink   (input valid, red, green, blue, degenerate, saturated, output ready);
endinterface

interface bci_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bci_pkg::CFG_IDX_W-1:0]      index;
  logic [bci_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/barycentric_color_interp_top.sv =====
// ----------------------------------------------------------------------------
// barycentric_color_interp_top
// Gouraud color of one pixel from three configured vertices and colors.
//
// Channels: in_pix takes one pixel (x, y, signed Q12.4) per beat; out_col
// gives one beat per pixel: red, green, blue (Q1.12, 0..4096), degenerate
// and saturated. cfg_wr writes vertex and color registers (index 0..5),
// always ready; write only while no pixel is in flight.
// One pixel is taken every cycle unless a stalled out_col has filled the
// pipeline; the two 33-step restoring dividers (one quotient bit per
// stage) set the depth, the pipeline sets the one-per-cycle rate.
// Each stage holds its beat until the next stage frees, so bubbles close
// up and in_pix stays ready while the pipeline has an empty slot, even
// when out_col is stalled. Nothing is dropped or repeated on a stall.
// Reset clears all stage valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module barycentric_color_interp_top (
  input  logic         clk,
  input  logic         rst_n,
  bci_pix_if.sink      in_pix,
  bci_color_if.source  out_col,
  bci_cfg_if.sink      cfg_wr
);

  localparam int NS = bci_pkg::N_ST;
  localparam int ND = bci_pkg::N_DIV;
  localparam int LW = bci_pkg::LANE_W;
  localparam int CW = bci_pkg::COORD_W;

  logic [bci_pkg::VTX_W-1:0] vtx_r [0:2];
  logic [bci_pkg::RGB_W-1:0] rgb_r [0:2];

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_col.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_pix.ready = adv[0];
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        vtx_r[k] <= '0;
        rgb_r[k] <= '0;
      end
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        bci_pkg::REG_VERTEX0: vtx_r[0] <= cfg_wr.data[bci_pkg::VTX_W-1:0];
        bci_pkg::REG_VERTEX1: vtx_r[1] <= cfg_wr.data[bci_pkg::VTX_W-1:0];
        bci_pkg::REG_VERTEX2: vtx_r[2] <= cfg_wr.data[bci_pkg::VTX_W-1:0];
        bci_pkg::REG_COLOR0:  rgb_r[0] <= cfg_wr.data;
        bci_pkg::REG_COLOR1:  rgb_r[1] <= cfg_wr.data;
        bci_pkg::REG_COLOR2:  rgb_r[2] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // vertex coordinates, sign-extended by one bit
  logic signed [bci_pkg::DIFF_W-1:0] vx [0:2];
  logic signed [bci_pkg::DIFF_W-1:0] vy [0:2];
  logic signed [bci_pkg::DIFF_W-1:0] px_e, py_e;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = {vtx_r[k][CW-1], vtx_r[k][CW-1:0]};
      vy[k] = {vtx_r[k][2*CW-1], vtx_r[k][2*CW-1:CW]};
    end
    px_e = {in_pix.pixel_x[CW-1], in_pix.pixel_x};
    py_e = {in_pix.pixel_y[CW-1], in_pix.pixel_y};
  end

  // stage 0: differences
  logic signed [bci_pkg::DIFF_W-1:0] dy12_r, dx20_r, dx21_r, dy02_r, dxp_r, dyp_r, dy20_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dy12_r <= vy[1] - vy[2];
      dx20_r <= vx[0] - vx[2];
      dx21_r <= vx[2] - vx[1];
      dy02_r <= vy[0] - vy[2];
      dy20_r <= vy[2] - vy[0];
      dxp_r  <= px_e - vx[2];
      dyp_r  <= py_e - vy[2];
    end
  end

  // stage 1: products
  logic signed [bci_pkg::PROD_W-1:0] pd1_r, pd2_r, pe01_r, pe02_r, pe11_r, pe12_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pd1_r  <= dy12_r * dx20_r;
      pd2_r  <= dx21_r * dy02_r;
      pe01_r <= dy12_r * dxp_r;
      pe02_r <= dx21_r * dyp_r;
      pe11_r <= dy20_r * dxp_r;
      pe12_r <= dx20_r * dyp_r;
    end
  end

  // stage 2: area term and edge functions
  logic signed [bci_pkg::SUM_W-1:0] d_r, e0_r, e1_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d_r  <= bci_pkg::SUM_W'(pd1_r) + bci_pkg::SUM_W'(pd2_r);
      e0_r <= bci_pkg::SUM_W'(pe01_r) + bci_pkg::SUM_W'(pe02_r);
      e1_r <= bci_pkg::SUM_W'(pe11_r) + bci_pkg::SUM_W'(pe12_r);
    end
  end

  // stage 3: magnitudes and signs
  logic [bci_pkg::SUM_W-1:0] ad_r;
  logic [bci_pkg::NUM_W-1:0] n0_r, n1_r;
  logic                      neg0_r, neg1_r, dgn_r;
  logic [bci_pkg::SUM_W-1:0] ae0, ae1;

  always_comb begin
    ae0 = e0_r[bci_pkg::SUM_W-1] ? -e0_r : e0_r;
    ae1 = e1_r[bci_pkg::SUM_W-1] ? -e1_r : e1_r;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ad_r   <= d_r[bci_pkg::SUM_W-1] ? -d_r : d_r;
      n0_r   <= {ae0, bci_pkg::WEIGHT_FRAC'(0)};
      n1_r   <= {ae1, bci_pkg::WEIGHT_FRAC'(0)};
      neg0_r <= e0_r[bci_pkg::SUM_W-1] ^ d_r[bci_pkg::SUM_W-1];
      neg1_r <= e1_r[bci_pkg::SUM_W-1] ^ d_r[bci_pkg::SUM_W-1];
      dgn_r  <= (d_r == '0);
    end
  end

  // dividers: one quotient bit per stage, MSB first
  logic [bci_pkg::SUM_W-1:0] dv_ad_r  [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r0_r  [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r1_r  [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q0_r  [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q1_r  [0:ND-1];
  logic                      dv_ng0_r [0:ND-1];
  logic                      dv_ng1_r [0:ND-1];
  logic                      dv_dgn_r [0:ND-1];

  logic [bci_pkg::SUM_W-1:0] dv_ad_src [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r0_src [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r1_src [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q0_src [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q1_src [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r0_nxt [0:ND-1];
  logic [bci_pkg::NUM_W-1:0] dv_r1_nxt [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q0_nxt [0:ND-1];
  logic [bci_pkg::QUO_W-1:0] dv_q1_nxt [0:ND-1];
  logic [bci_pkg::CMP_W-1:0] dv_sh    [0:ND-1];
  logic                      dv_b0    [0:ND-1];
  logic                      dv_b1    [0:ND-1];

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      if (j == 0) begin
        dv_ad_src[j] = ad_r;
        dv_r0_src[j] = n0_r;
        dv_r1_src[j] = n1_r;
        dv_q0_src[j] = '0;
        dv_q1_src[j] = '0;
      end else begin
        dv_ad_src[j] = dv_ad_r[j-1];
        dv_r0_src[j] = dv_r0_r[j-1];
        dv_r1_src[j] = dv_r1_r[j-1];
        dv_q0_src[j] = dv_q0_r[j-1];
        dv_q1_src[j] = dv_q1_r[j-1];
      end
      dv_sh[j] = bci_pkg::CMP_W'(dv_ad_src[j]) << (ND - 1 - j);
      dv_b0[j] = bci_pkg::CMP_W'(dv_r0_src[j]) >= dv_sh[j];
      dv_b1[j] = bci_pkg::CMP_W'(dv_r1_src[j]) >= dv_sh[j];
      dv_r0_nxt[j] = dv_b0[j] ? dv_r0_src[j] - bci_pkg::NUM_W'(dv_sh[j]) : dv_r0_src[j];
      dv_r1_nxt[j] = dv_b1[j] ? dv_r1_src[j] - bci_pkg::NUM_W'(dv_sh[j]) : dv_r1_src[j];
      dv_q0_nxt[j] = {dv_q0_src[j][bci_pkg::QUO_W-2:0], dv_b0[j]};
      dv_q1_nxt[j] = {dv_q1_src[j][bci_pkg::QUO_W-2:0], dv_b1[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ND; j++) begin
      if (adv[bci_pkg::ST_DIV0 + j]) begin
        dv_ad_r[j] <= dv_ad_src[j];
        dv_r0_r[j] <= dv_r0_nxt[j];
        dv_r1_r[j] <= dv_r1_nxt[j];
        dv_q0_r[j] <= dv_q0_nxt[j];
        dv_q1_r[j] <= dv_q1_nxt[j];
        if (j == 0) begin
          dv_ng0_r[j] <= neg0_r;
          dv_ng1_r[j] <= neg1_r;
          dv_dgn_r[j] <= dgn_r;
        end else begin
          dv_ng0_r[j] <= dv_ng0_r[j-1];
          dv_ng1_r[j] <= dv_ng1_r[j-1];
          dv_dgn_r[j] <= dv_dgn_r[j-1];
        end
      end
    end
  end

  // weights; a set top quotient bit means the magnitude clamps to 2^32
  logic signed [bci_pkg::WGT_W-1:0] w0_r, w1_r;
  logic signed [bci_pkg::W2_W-1:0]  w2_r;
  logic                             wdgn_r;
  logic [bci_pkg::QUO_W-1:0]        mag0, mag1;
  logic signed [bci_pkg::WGT_W-1:0] sw0, sw1;

  always_comb begin
    mag0 = dv_q0_r[ND-1][bci_pkg::QUO_W-1] ? (bci_pkg::QUO_W'(1) << (bci_pkg::QUO_W-1))
                                           : dv_q0_r[ND-1];
    mag1 = dv_q1_r[ND-1][bci_pkg::QUO_W-1] ? (bci_pkg::QUO_W'(1) << (bci_pkg::QUO_W-1))
                                           : dv_q1_r[ND-1];
    sw0 = dv_ng0_r[ND-1] ? -$signed({1'b0, mag0}) : $signed({1'b0, mag0});
    sw1 = dv_ng1_r[ND-1] ? -$signed({1'b0, mag1}) : $signed({1'b0, mag1});
  end

  always_ff @(posedge clk) begin
    if (adv[bci_pkg::ST_WGT]) begin
      w0_r   <= sw0;
      w1_r   <= sw1;
      w2_r   <= (bci_pkg::W2_W'(1) <<< bci_pkg::WEIGHT_FRAC)
                - bci_pkg::W2_W'(sw0) - bci_pkg::W2_W'(sw1);
      wdgn_r <= dv_dgn_r[ND-1];
    end
  end

  // lane products, index ch*3 + vertex
  logic signed [bci_pkg::MUL_W-1:0] mp_r [0:8];
  logic                             mdgn_r;
  logic signed [LW:0]               lane_s [0:8];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        lane_s[ch*3+k] = $signed({1'b0, rgb_r[k][ch*LW +: LW]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[bci_pkg::ST_MUL]) begin
      for (int ch = 0; ch < 3; ch++) begin
        mp_r[ch*3+0] <= lane_s[ch*3+0] * bci_pkg::W2_W'(w0_r);
        mp_r[ch*3+1] <= lane_s[ch*3+1] * bci_pkg::W2_W'(w1_r);
        mp_r[ch*3+2] <= lane_s[ch*3+2] * w2_r;
      end
      mdgn_r <= wdgn_r;
    end
  end

  // channel sums with half-LSB rounding
  logic signed [bci_pkg::ACC_W-1:0] acc_r [0:2];
  logic                             adgn_r;

  always_ff @(posedge clk) begin
    if (adv[bci_pkg::ST_ACC]) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= bci_pkg::ACC_W'(mp_r[ch*3+0]) + bci_pkg::ACC_W'(mp_r[ch*3+1])
                   + bci_pkg::ACC_W'(mp_r[ch*3+2])
                   + (bci_pkg::ACC_W'(1) <<< (bci_pkg::WEIGHT_FRAC - 1));
      end
      adgn_r <= mdgn_r;
    end
  end

  // clamp and output register
  logic [LW-1:0]                    ch_nxt [0:2];
  logic [2:0]                       ch_sat;
  logic [bci_pkg::ACC_W-1:0]        shr [0:2];
  logic [LW-1:0]                    red_r, green_r, blue_r;
  logic                             odgn_r, osat_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      shr[ch] = bci_pkg::ACC_W'(acc_r[ch] >>> bci_pkg::WEIGHT_FRAC);
      if (adgn_r) begin
        ch_sat[ch] = rgb_r[0][ch*LW +: LW] > bci_pkg::COLOR_ONE;
        ch_nxt[ch] = ch_sat[ch] ? bci_pkg::COLOR_ONE : rgb_r[0][ch*LW +: LW];
      end else if (acc_r[ch] < 0) begin
        ch_sat[ch] = 1'b1;
        ch_nxt[ch] = '0;
      end else if (shr[ch] > bci_pkg::ACC_W'(bci_pkg::COLOR_ONE)) begin
        ch_sat[ch] = 1'b1;
        ch_nxt[ch] = bci_pkg::COLOR_ONE;
      end else begin
        ch_sat[ch] = 1'b0;
        ch_nxt[ch] = shr[ch][LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[bci_pkg::ST_OUT]) begin
      red_r   <= ch_nxt[0];
      green_r <= ch_nxt[1];
      blue_r  <= ch_nxt[2];
      odgn_r  <= adgn_r;
      osat_r  <= |ch_sat;
    end
  end

  assign out_col.valid      = vld_r[NS-1];
  assign out_col.red        = red_r;
  assign out_col.green      = green_r;
  assign out_col.blue       = blue_r;
  assign out_col.degenerate = odgn_r;
  assign out_col.saturated  = osat_r;

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_col.valid |-> (red_r <= bci_pkg::COLOR_ONE) && (green_r <= bci_pkg::COLOR_ONE)
                      && (blue_r <= bci_pkg::COLOR_ONE))
    else $error("output channel above full scale");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] && !adv[NS-2] |=> vld_r[NS-2])
    else $error("stalled beat lost before the output stage");

endmodule

// ===== dv/barycentric_color_interp_top_tb.sv =====
// ----------------------------------------------------------------------------
// barycentric_color_interp_top_tb
// Drives pixels through the color interpolator across several triangle and
// color setups, predicts each color beat from the configured vertices and
// colors and checks each whole result beat in order against the prediction.
// ----------------------------------------------------------------------------
module barycentric_color_interp_top_tb;

  localparam int LATENCY    = 41;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [bci_pkg::COORD_W-1:0] x;
    logic signed [bci_pkg::COORD_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [bci_pkg::LANE_W-1:0] red;
    logic [bci_pkg::LANE_W-1:0] green;
    logic [bci_pkg::LANE_W-1:0] blue;
    logic                       degenerate;
    logic                       saturated;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bci_pix_if   pix_ch ();
  bci_color_if col_ch ();
  bci_cfg_if   cfg_ch ();

  barycentric_color_interp_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch.sink),
    .out_col (col_ch.source),
    .cfg_wr  (cfg_ch.sink)
  );

  always #1 clk = ~clk;

  logic [bci_pkg::VTX_W-1:0] tri_xy  [3];
  logic [bci_pkg::RGB_W-1:0] tri_rgb [3];

  pixel_t pixel_q [$];
  color_t color_q [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  busy_idle = 1'b1;
  bit  pix_taken = 1'b0;

  function automatic longint signed sx(input logic [bci_pkg::COORD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint signed bary_weight(input longint signed e,
                                                input longint signed d);
    bit neg;
    longint unsigned ae, ad, q, r, mag;
    neg = (e < 0) != (d < 0);
    ae  = e < 0 ? -e : e;
    ad  = d < 0 ? -d : d;
    q   = ae / ad;
    r   = ae % ad;
    if (q >= 64'd65536) mag = 64'd1 << (bci_pkg::WEIGHT_FRAC + 16);
    else begin
      mag = (q << bci_pkg::WEIGHT_FRAC) + (r << bci_pkg::WEIGHT_FRAC) / ad;
      if (mag > (64'd1 << (bci_pkg::WEIGHT_FRAC + 16)))
        mag = 64'd1 << (bci_pkg::WEIGHT_FRAC + 16);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic color_t shade_pixel(input pixel_t p);
    longint signed x0, y0, x1, y1, x2, y2, px, py, d, e0, e1, w0, w1, w2, t;
    longint signed c;
    longint signed lane_v [3][3];
    color_t res;
    x0 = sx(tri_xy[0][15:0]); y0 = sx(tri_xy[0][31:16]);
    x1 = sx(tri_xy[1][15:0]); y1 = sx(tri_xy[1][31:16]);
    x2 = sx(tri_xy[2][15:0]); y2 = sx(tri_xy[2][31:16]);
    px = sx(p.x); py = sx(p.y);
    for (int k = 0; k < 3; k++)
      for (int ch = 0; ch < 3; ch++)
        lane_v[k][ch] = longint'(tri_rgb[k][ch*bci_pkg::LANE_W +: bci_pkg::LANE_W]);
    res = '0;
    d = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
    if (d == 0) begin
      res.degenerate = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        c = lane_v[0][ch];
        if (c > 4096) begin c = 4096; res.saturated = 1'b1; end
        if (ch == 0) res.red = bci_pkg::LANE_W'(c);
        else if (ch == 1) res.green = bci_pkg::LANE_W'(c);
        else res.blue = bci_pkg::LANE_W'(c);
      end
      return res;
    end
    e0 = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
    e1 = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
    w0 = bary_weight(e0, d);
    w1 = bary_weight(e1, d);
    w2 = (64'sd1 << bci_pkg::WEIGHT_FRAC) - w0 - w1;
    for (int ch = 0; ch < 3; ch++) begin
      t = lane_v[0][ch] * w0 + lane_v[1][ch] * w1 + lane_v[2][ch] * w2
        + (64'sd1 << (bci_pkg::WEIGHT_FRAC - 1));
      if (t < 0) begin c = 0; res.saturated = 1'b1; end
      else begin
        c = t >>> bci_pkg::WEIGHT_FRAC;
        if (c > 4096) begin c = 4096; res.saturated = 1'b1; end
      end
      if (ch == 0) res.red = bci_pkg::LANE_W'(c);
      else if (ch == 1) res.green = bci_pkg::LANE_W'(c);
      else res.blue = bci_pkg::LANE_W'(c);
    end
    return res;
  endfunction

  // pixel driver
  always @(posedge clk)
    pix_taken <= pix_ch.valid && pix_ch.ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_taken) begin
      if (pix_taken) void'(pixel_q.pop_front());
      if (pixel_q.size() > 0 && (busy_idle || $urandom_range(99) >= 32)) begin
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= pixel_q[0].x;
        pix_ch.pixel_y <= pixel_q[0].y;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    col_ch.ready <= rst_n && (busy_idle || $urandom_range(99) >= 32);

  // monitor and checker
  always @(posedge clk) begin
    color_t got, want;
    if (rst_n) begin
      if (pix_ch.valid && pix_ch.ready) begin
        color_q.push_back(shade_pixel({pix_ch.pixel_x, pix_ch.pixel_y}));
      end
      if (col_ch.valid && col_ch.ready) begin
        got = {col_ch.red, col_ch.green, col_ch.blue, col_ch.degenerate,
               col_ch.saturated};
        if (color_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected color beat %p", got);
        end else begin
          want = color_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("color mismatch: expected %p got %p", want, got);
          end
        end
      end
      if ((pix_ch.valid && pix_ch.ready) || (col_ch.valid && col_ch.ready) ||
          (color_q.size() == 0 && pixel_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** barycentric_color_interp_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input bci_pkg::cfg_idx_t idx,
                           input logic [bci_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < bci_pkg::REG_COLOR0) tri_xy[idx] = val[bci_pkg::VTX_W-1:0];
    else tri_rgb[idx - bci_pkg::REG_COLOR0] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || color_q.size() != 0 || pix_ch.valid) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [bci_pkg::COORD_W-1:0] rand_coord(input int span);
    return span == 0 ? bci_pkg::COORD_W'($urandom)
                     : bci_pkg::COORD_W'($urandom_range(2*span) - span);
  endfunction

  task automatic setup_triangle(input int span, input bit wide_color);
    logic [bci_pkg::CFG_DATA_W-1:0] c;
    for (int k = 0; k < 3; k++)
      write_reg(bci_pkg::cfg_idx_t'(bci_pkg::REG_VERTEX0 + k),
                {rand_coord(span), rand_coord(span)});
    for (int k = 0; k < 3; k++) begin
      if (wide_color) c = bci_pkg::CFG_DATA_W'({$urandom, $urandom});
      else c = {13'($urandom_range(4096)), 13'($urandom_range(4096)),
                13'($urandom_range(4096))};
      write_reg(bci_pkg::cfg_idx_t'(bci_pkg::REG_COLOR0 + k), c);
    end
  endtask

  task automatic queue_pixels(input int n, input int span);
    for (int i = 0; i < n; i++)
      pixel_q.push_back({rand_coord(span), rand_coord(span)});
    drain();
  endtask

  initial begin
    pix_ch.valid = 1'b0; pix_ch.pixel_x = '0; pix_ch.pixel_y = '0;
    col_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = bci_pkg::REG_VERTEX0; cfg_ch.data = '0;
    foreach (tri_xy[k]) begin tri_xy[k] = '0; tri_rgb[k] = '0; end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: degenerate triangle, black
    pixel_q.push_back({16'sh7FFF, 16'sh8000});
    drain();

    // directed: unit-ish triangle with full-scale colors
    write_reg(bci_pkg::REG_VERTEX0, {16'sd0, 16'sd0});
    write_reg(bci_pkg::REG_VERTEX1, {16'sd0, 16'sd256});
    write_reg(bci_pkg::REG_VERTEX2, {16'sd256, 16'sd0});
    write_reg(bci_pkg::REG_COLOR0, {13'd0, 13'd0, 13'd4096});
    write_reg(bci_pkg::REG_COLOR1, {13'd0, 13'd4096, 13'd0});
    write_reg(bci_pkg::REG_COLOR2, {13'd4096, 13'd0, 13'd0});
    pixel_q.push_back({16'sd0, 16'sd0});
    pixel_q.push_back({16'sd0, 16'sd256});
    pixel_q.push_back({16'sd256, 16'sd0});
    pixel_q.push_back({16'sd64, 16'sd64});
    pixel_q.push_back({16'sh7FFF, 16'sh7FFF});
    pixel_q.push_back({16'sh8000, 16'sh8000});
    pixel_q.push_back({16'sh8000, 16'sh7FFF});
    pixel_q.push_back({16'sh7FFF, 16'sh8000});
    pixel_q.push_back({16'sd2000, 16'sd2000});
    drain();
    // extreme weights: tiny area, far pixel
    write_reg(bci_pkg::REG_VERTEX1, {16'sd0, 16'sd1});
    write_reg(bci_pkg::REG_VERTEX2, {16'sd1, 16'sd0});
    pixel_q.push_back({16'sh7FFF, 16'sh8000});
    pixel_q.push_back({16'sh8000, 16'sh7FFF});
    pixel_q.push_back({16'sd1, 16'sd1});
    drain();
    // extreme vertices, lanes above one
    write_reg(bci_pkg::REG_VERTEX0, {16'sh8000, 16'sh8000});
    write_reg(bci_pkg::REG_VERTEX1, {16'sh7FFF, 16'sh8000});
    write_reg(bci_pkg::REG_VERTEX2, {16'sh8000, 16'sh7FFF});
    write_reg(bci_pkg::REG_COLOR0, {bci_pkg::CFG_DATA_W{1'b1}});
    write_reg(bci_pkg::REG_COLOR1, '0);
    write_reg(bci_pkg::REG_COLOR2, {13'h1FFF, 13'd0, 13'h1FFF});
    pixel_q.push_back({16'sd0, 16'sd0});
    pixel_q.push_back({16'sh7FFF, 16'sh7FFF});
    pixel_q.push_back({16'sh8000, 16'sh8000});
    drain();
    // degenerate with lanes above one: collinear vertices
    write_reg(bci_pkg::REG_VERTEX2, {16'sh8000, 16'sh8000});
    pixel_q.push_back({16'sd5, 16'sd5});
    pixel_q.push_back({16'sh8000, 16'sh7FFF});
    drain();

    for (int ph = 0; ph < 15; ph++) begin
      busy_idle = (ph == 4 || ph == 5);
      case (ph % 4)
        0: begin setup_triangle(512, 1'b0); queue_pixels(110, 600); end
        1: begin setup_triangle(0, 1'b1);   queue_pixels(110, 0); end
        2: begin setup_triangle(40, 1'b0);  queue_pixels(110, 64); end
        default: begin setup_triangle(3, 1'b1); queue_pixels(110, 0); end
      endcase
    end
    busy_idle = 1'b0;

    if (mismatches == 0) $display("** barycentric_color_interp_top: PASSED **");
    else $display("** barycentric_color_interp_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bci_pkg.sv
hdl/bci_if.sv
hdl/barycentric_color_interp_top.sv
dv/barycentric_color_interp_top_tb.sv
